// ===== sv/wtsc_pkg.sv =====
`timescale 1ns / 1ps
// Package for the wave-table sound channel: operation codes, register
// offsets, volume table and the structs passed between its modules.
// No dependencies.
package wtsc_pkg;

  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;
  localparam logic [1:0] OP_LEN   = 2'd3;

  localparam logic [7:0] ADDR_CTRL    = 8'h70;
  localparam logic [7:0] ADDR_LV_LO   = 8'h72;
  localparam logic [7:0] ADDR_LV_HI   = 8'h73;
  localparam logic [7:0] ADDR_FREQ_LO = 8'h74;
  localparam logic [7:0] ADDR_FREQ_HI = 8'h75;
  localparam logic [7:0] ADDR_WAVE_LO = 8'h90;
  localparam logic [7:0] ADDR_WAVE_HI = 8'h9F;

  localparam logic [7:0] LV_RD_MASK = 8'hE0;
  localparam logic [7:0] FC_RD_MASK = 8'h40;

  // Read data source codes
  localparam logic [1:0] RD_ZERO = 2'd0;
  localparam logic [1:0] RD_REG  = 2'd1;
  localparam logic [1:0] RD_WAVE = 2'd2;

  localparam int unsigned QDEPTH = 3;

  localparam logic [2:0] VOL_TABLE [4] = '{3'd0, 3'd4, 3'd2, 3'd1};
  localparam logic [2:0] VOL_FORCE = 3'd3;

  typedef struct packed {
    logic       we;
    logic [4:0] widx;
    logic [7:0] wdata;
    logic [4:0] amp_idx;
    logic [4:0] bus_idx;
  } mem_req_t;

  typedef struct packed {
    logic [1:0] rd_src;
    logic [7:0] rd_reg;
    logic       nib_lo;
    logic [2:0] vol;
    logic       gate;
    logic       playing;
  } s1_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic [3:0] amplitude;
    logic       playing;
  } result_t;

  // (2048 - f) * 8, at most 16384
  function automatic logic [14:0] period_len(input logic [10:0] f);
    logic [11:0] d;
    d = 12'd2048 - {1'b0, f};
    return {d, 3'b000};
  endfunction

  // (256 - n) * 2, at most 512
  function automatic logic [9:0] length_len(input logic [7:0] n);
    logic [8:0] d;
    d = 9'd256 - {1'b0, n};
    return {d, 1'b0};
  endfunction

endpackage

// ===== sv/wtsc_in_if.sv =====
`timescale 1ns / 1ps
// Input channel interface: valid/ready handshake carrying one bus or tick item.
// No dependencies.
interface wtsc_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] op;
  logic [7:0] address;
  logic [7:0] write_data;

  modport source (output valid, output op, output address, output write_data, input ready);
  modport sink   (input valid, input op, input address, input write_data, output ready);
endinterface

// ===== sv/wtsc_out_if.sv =====
`timescale 1ns / 1ps
// Result channel interface: valid/ready handshake carrying read data, amplitude
// and the playing flag. No dependencies.
interface wtsc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [3:0] amplitude;
  logic       playing;

  modport source (output valid, output read_data, output amplitude, output playing,
                  input ready);
  modport sink   (input valid, input read_data, input amplitude, input playing,
                  output ready);
endinterface

// ===== sv/wtsc_ctrl.sv =====
`timescale 1ns / 1ps
// Register file, period/length counters and wave position of the channel.
// Produces the wave memory request and the stage-one result fields. Uses wtsc_pkg.
module wtsc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [1:0]          op,
  input  logic [7:0]          address,
  input  logic [7:0]          write_data,
  output wtsc_pkg::mem_req_t  mem_req,
  output wtsc_pkg::s1_t       s1_r,
  output logic                s1_valid_r
);

  logic [2:0]  sel_r,  sel_nxt;
  logic [15:0] lv_r,   lv_nxt;
  logic [15:0] fc_r,   fc_nxt;
  logic        en_r,   en_nxt;
  logic [9:0]  len_r,  len_nxt;
  logic [5:0]  pos_r,  pos_nxt;
  logic [14:0] per_r,  per_nxt;
  logic        run_r,  run_nxt;
  wtsc_pkg::s1_t s1_nxt;

  logic        is_wave;
  logic [4:0]  bus_idx;
  logic [5:0]  idx;
  logic [9:0]  len_dec;

  assign is_wave = (address >= wtsc_pkg::ADDR_WAVE_LO) && (address <= wtsc_pkg::ADDR_WAVE_HI);
  // In one-bank mode the bus reaches the bank that is not playing
  assign bus_idx = {~sel_r[1], address[3:0]};
  assign len_dec = len_r - 10'd1;

  always_comb begin
    sel_nxt = sel_r;
    lv_nxt  = lv_r;
    fc_nxt  = fc_r;
    en_nxt  = en_r;
    len_nxt = len_r;
    pos_nxt = pos_r;
    per_nxt = per_r;
    run_nxt = run_r;
    s1_nxt  = '0;
    s1_nxt.rd_src = wtsc_pkg::RD_ZERO;

    unique case (op)
      wtsc_pkg::OP_READ: begin
        if (is_wave) begin
          s1_nxt.rd_src = wtsc_pkg::RD_WAVE;
        end else begin
          unique case (address)
            wtsc_pkg::ADDR_CTRL: begin
              s1_nxt.rd_src = wtsc_pkg::RD_REG;
              s1_nxt.rd_reg = {sel_r, 5'b00000};
            end
            wtsc_pkg::ADDR_LV_HI: begin
              s1_nxt.rd_src = wtsc_pkg::RD_REG;
              s1_nxt.rd_reg = lv_r[15:8] & wtsc_pkg::LV_RD_MASK;
            end
            wtsc_pkg::ADDR_FREQ_HI: begin
              s1_nxt.rd_src = wtsc_pkg::RD_REG;
              s1_nxt.rd_reg = fc_r[15:8] & wtsc_pkg::FC_RD_MASK;
            end
            default: ;
          endcase
        end
      end
      wtsc_pkg::OP_WRITE: begin
        unique case (address)
          wtsc_pkg::ADDR_CTRL:    sel_nxt = write_data[7:5];
          wtsc_pkg::ADDR_LV_LO:   lv_nxt  = {lv_r[15:8], write_data};
          wtsc_pkg::ADDR_LV_HI:   lv_nxt  = {write_data, lv_r[7:0]};
          wtsc_pkg::ADDR_FREQ_LO: fc_nxt  = {fc_r[15:8], write_data};
          wtsc_pkg::ADDR_FREQ_HI: begin
            fc_nxt = {write_data, fc_r[7:0]};
            // Trigger: restart playback
            if (write_data[7]) begin
              en_nxt  = 1'b1;
              len_nxt = wtsc_pkg::length_len(lv_r[7:0]);
              pos_nxt = '0;
              per_nxt = wtsc_pkg::period_len({write_data[2:0], fc_r[7:0]});
              run_nxt = 1'b1;
            end
          end
          default: ;
        endcase
      end
      wtsc_pkg::OP_TICK: begin
        if (run_r) begin
          if (per_r <= 15'd1) begin
            pos_nxt = sel_r[0] ? (pos_r + 6'd1) : {1'b0, pos_r[4:0] + 5'd1};
            per_nxt = wtsc_pkg::period_len(fc_r[10:0]);
          end else begin
            per_nxt = per_r - 15'd1;
          end
        end
      end
      wtsc_pkg::OP_LEN: begin
        if (fc_r[14] && (len_r != '0)) begin
          len_nxt = len_dec;
          if (len_dec == '0) en_nxt = 1'b0;
        end
      end
      default: ;
    endcase

    // One-bank mode with the bank bit set plays the upper half
    idx = pos_nxt;
    if (sel_nxt[1] && !sel_nxt[0]) idx[5] = ~pos_nxt[5];

    s1_nxt.nib_lo  = idx[0];
    s1_nxt.playing = en_nxt;
    s1_nxt.gate    = en_nxt && sel_nxt[2];
    s1_nxt.vol     = lv_nxt[15] ? wtsc_pkg::VOL_FORCE : wtsc_pkg::VOL_TABLE[lv_nxt[14:13]];
  end

  always_comb begin
    mem_req.we      = acc && (op == wtsc_pkg::OP_WRITE) && is_wave;
    mem_req.widx    = bus_idx;
    mem_req.wdata   = write_data;
    mem_req.amp_idx = idx[5:1];
    mem_req.bus_idx = bus_idx;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r      <= '0;
      lv_r       <= '0;
      fc_r       <= '0;
      en_r       <= 1'b0;
      len_r      <= '0;
      pos_r      <= '0;
      per_r      <= '0;
      run_r      <= 1'b0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= acc;
      if (acc) begin
        sel_r <= sel_nxt;
        lv_r  <= lv_nxt;
        fc_r  <= fc_nxt;
        en_r  <= en_nxt;
        len_r <= len_nxt;
        pos_r <= pos_nxt;
        per_r <= per_nxt;
        run_r <= run_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
  end

endmodule

// ===== sv/wtsc_wave_mem.sv =====
`timescale 1ns / 1ps
// Wave byte memory, 32 x 8, one write and two registered reads per cycle.
// Valid bits stand in for the zero reset; an amplitude read of the entry written in the
// same cycle returns the new byte. Uses wtsc_pkg.
module wtsc_wave_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  wtsc_pkg::mem_req_t req,
  output logic [7:0]         amp_byte,
  output logic [7:0]         bus_byte
);

  logic [7:0] mem [32];
  logic [31:0] vld_r;
  logic [7:0] amp_raw_r, bus_raw_r, wdata_r;
  logic       amp_v_r, bus_v_r, amp_fwd_r;

  always_ff @(posedge clk) begin
    if (req.we) mem[req.widx] <= req.wdata;
    amp_raw_r <= mem[req.amp_idx];
    bus_raw_r <= mem[req.bus_idx];
    wdata_r   <= req.wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      amp_v_r   <= 1'b0;
      bus_v_r   <= 1'b0;
      amp_fwd_r <= 1'b0;
    end else begin
      if (req.we) vld_r[req.widx] <= 1'b1;
      amp_v_r   <= vld_r[req.amp_idx];
      bus_v_r   <= vld_r[req.bus_idx];
      amp_fwd_r <= req.we && (req.widx == req.amp_idx);
    end
  end

  assign amp_byte = amp_fwd_r ? wdata_r : (amp_v_r ? amp_raw_r : 8'h00);
  assign bus_byte = bus_v_r ? bus_raw_r : 8'h00;

endmodule

// ===== sv/wtsc_out_q.sv =====
`timescale 1ns / 1ps
// Three-entry result queue between the datapath and the result channel.
// Uses wtsc_pkg.
module wtsc_out_q (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  wtsc_pkg::result_t din,
  input  logic              pop,
  output wtsc_pkg::result_t dout,
  output logic [1:0]        cnt_r
);

  wtsc_pkg::result_t q_r [wtsc_pkg::QDEPTH];
  logic [1:0] wp_r, rp_r, cnt_nxt;

  function automatic logic [1:0] ptr_inc(input logic [1:0] p);
    return (p == 2'(wtsc_pkg::QDEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = cnt_r + 2'd1;
    if (!push && pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ptr_inc(wp_r);
      if (pop)  rp_r <= ptr_inc(rp_r);
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= din;
  end

  assign dout = q_r[rp_r];

endmodule

// ===== sv/wave_table_sound_channel.sv =====
`timescale 1ns / 1ps
// Wave-table sound channel, top level.
// Path: an accepted item updates the state registers and the wave memory read registers,
// then its result is written to the result queue and offered from there.
// Throughput: one item per cycle while in_ch.ready is high; the three-entry result queue absorbs stalls.
// Reset (rst_n, synchronous): all registers, counters and wave bytes read zero.
module wave_table_sound_channel (
  input  logic        clk,
  input  logic        rst_n,
  wtsc_in_if.sink     in_ch,
  wtsc_out_if.source  out_ch
);

  wtsc_pkg::mem_req_t mem_req;
  wtsc_pkg::s1_t      s1_r;
  wtsc_pkg::result_t  res, q_dout;
  logic               s1_valid_r, in_acc, pop;
  logic [7:0]         amp_byte, bus_byte;
  logic [3:0]         nib;
  logic [5:0]         prod;
  logic [1:0]         q_cnt;
  logic [2:0]         fill;

  assign fill         = {2'b00, s1_valid_r} + {1'b0, q_cnt};
  assign in_ch.ready  = fill < 3'(wtsc_pkg::QDEPTH);
  assign in_acc       = in_ch.valid && in_ch.ready;

  wtsc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (in_acc),
    .op         (in_ch.op),
    .address    (in_ch.address),
    .write_data (in_ch.write_data),
    .mem_req    (mem_req),
    .s1_r       (s1_r),
    .s1_valid_r (s1_valid_r)
  );

  wtsc_wave_mem u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (mem_req),
    .amp_byte (amp_byte),
    .bus_byte (bus_byte)
  );

  assign nib  = s1_r.nib_lo ? amp_byte[3:0] : amp_byte[7:4];
  assign prod = {2'b00, nib} * {3'b000, s1_r.vol};

  always_comb begin
    res.playing   = s1_r.playing;
    res.amplitude = s1_r.gate ? prod[5:2] : 4'd0;
    case (s1_r.rd_src)
      wtsc_pkg::RD_REG:  res.read_data = s1_r.rd_reg;
      wtsc_pkg::RD_WAVE: res.read_data = bus_byte;
      default:           res.read_data = 8'h00;
    endcase
  end

  assign pop = out_ch.valid && out_ch.ready;

  wtsc_out_q u_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (s1_valid_r),
    .din   (res),
    .pop   (pop),
    .dout  (q_dout),
    .cnt_r (q_cnt)
  );

  assign out_ch.valid     = q_cnt != 2'd0;
  assign out_ch.read_data = q_dout.read_data;
  assign out_ch.amplitude = q_dout.amplitude;
  assign out_ch.playing   = q_dout.playing;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |-> (q_cnt != 2'(wtsc_pkg::QDEPTH)))
    else $error("result queue overflow");

  a_amp_needs_play: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && (out_ch.amplitude != 4'd0)) |-> out_ch.playing)
    else $error("nonzero amplitude while channel disabled");

  a_trigger_enables: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.op == wtsc_pkg::OP_WRITE) &&
     (in_ch.address == wtsc_pkg::ADDR_FREQ_HI) && in_ch.write_data[7])
    |=> (s1_valid_r && s1_r.playing))
    else $error("trigger write did not enable the channel");

  a_read_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && (in_ch.op != wtsc_pkg::OP_READ)) |=> (s1_r.rd_src == wtsc_pkg::RD_ZERO))
    else $error("read data selected for a non-read transaction");

endmodule
